[design/sms_pkg.sv]
package sms_pkg;

    // item commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // opcodes
    localparam logic [15:0] OP_HALT  = 16'd0;
    localparam logic [15:0] OP_ADD   = 16'd1;
    localparam logic [15:0] OP_DOT   = 16'd2;
    localparam logic [15:0] OP_MPY   = 16'd3;
    localparam logic [15:0] OP_SUB   = 16'd4;
    localparam logic [15:0] OP_UNLK  = 16'd5;
    localparam logic [15:0] OP_CMP   = 16'd6;
    localparam logic [15:0] OP_BAD   = 16'd7;
    localparam logic [15:0] OP_CALL  = 16'd8;
    localparam logic [15:0] OP_EXIT  = 16'd9;
    localparam logic [15:0] OP_INT   = 16'd10;
    localparam logic [15:0] OP_JMP   = 16'd11;
    localparam logic [15:0] OP_JZR   = 16'd12;
    localparam logic [15:0] OP_LINK  = 16'd13;
    localparam logic [15:0] OP_LOAD  = 16'd14;
    localparam logic [15:0] OP_STORE = 16'd15;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_OPCODE = 2'd1;
    localparam logic [1:0] ERR_STACK  = 2'd2;
    localparam logic [1:0] ERR_CODE   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FRAME,
        ST_EXEC
    } sms_state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [9:0]         code_address;
        logic signed [15:0] code_word;
    } sms_req_t;

    typedef struct packed {
        logic [9:0]         program_counter_out;
        logic [10:0]        stack_pointer_out;
        logic signed [15:0] print_value;
        logic               print_valid;
        logic               halted;
        logic [1:0]         error_code;
    } sms_rsp_t;

    // outcome flags of one instruction
    typedef struct packed {
        logic [1:0]  error_code;
        logic        halted;
        logic        print_valid;
        logic [15:0] print_value;
    } sms_status_t;

endpackage

[design/stack_machine_step.sv]
// 16-bit stack machine core. Each request transaction carries a command: a
// code write stores one word in the code memory, a start clears the program
// counter, stack pointer and frame pointer, and a step executes the
// instruction at the program counter. Every request gives exactly one
// response transaction with the program counter and stack pointer after it,
// the value printed by DOT, the halt flag and an error code; a faulting step
// changes nothing. Code writes and starts can be issued every cycle unless
// the response stalls. A step runs the read, frame and execute states and a
// new request is taken in execute: read fetches the opcode, operand and the
// two top stack entries, frame reads the frame slot from the stack memory,
// and execute executes and writes back into it. The response register
// decouples the two sides, so a stalled response only holds the core once
// the next instruction is ready to retire. No clearing pass follows reset.
module stack_machine_step
    import sms_pkg::*;
#(
    parameter int CODE_DEPTH  = 1024,
    parameter int STACK_DEPTH = 1024
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  sms_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output sms_rsp_t rsp
);

    localparam int CAW = $clog2(CODE_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    sms_state_t     state_reg;
    sms_state_t     state_next;
    sms_req_t       item_reg;
    logic [CAW-1:0] pc_reg;
    logic [CAW-1:0] pc_next;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    logic [SAW-1:0] fp_reg;
    logic [SAW-1:0] fp_next;
    logic [15:0]    second_reg;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    sms_rsp_t       rsp_reg;
    sms_rsp_t       rsp_next;

    logic           accept;
    logic           out_free;
    logic           commit;
    logic           exec_ok;
    logic           code_in_range;

    logic [15:0]    code_op;
    logic [15:0]    code_arg;
    logic [15:0]    stack_top;
    logic [15:0]    stack_b;
    logic           stack_rd_en_b;
    logic [SAW-1:0] stack_rd_addr_b;

    logic [SAW-1:0] alu_frame_addr;
    sms_status_t    alu_status;
    logic [CAW-1:0] alu_pc;
    logic [SPW-1:0] alu_sp;
    logic [SAW-1:0] alu_fp;
    logic           alu_wr_en;
    logic [SAW-1:0] alu_wr_addr;
    logic [15:0]    alu_wr_data;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_EXEC) && out_free));
    assign accept    = req_valid && !req_stall;
    assign commit    = (state_reg == ST_EXEC) && out_free;
    assign exec_ok   = (alu_status.error_code == ERR_NONE) && !alu_status.halted;
    assign code_in_range = 32'(item_reg.code_address) < CODE_DEPTH;

    sms_ram #(
        .DEPTH (CODE_DEPTH),
        .WIDTH (16)
    ) u_code_ram (
        .clk       (clk),
        .wr_en     (commit && (item_reg.command == CMD_WRITE) && code_in_range),
        .wr_addr   (CAW'(item_reg.code_address)),
        .wr_data   (item_reg.code_word),
        .rd_en_a   (state_reg == ST_READ),
        .rd_addr_a (pc_reg),
        .rd_data_a (code_op),
        .rd_en_b   (state_reg == ST_READ),
        .rd_addr_b (CAW'(pc_reg + CAW'(1))),
        .rd_data_b (code_arg)
    );

    // port b first fetches the second entry, then the frame slot
    assign stack_rd_en_b   = (state_reg == ST_READ) || (state_reg == ST_FRAME);
    assign stack_rd_addr_b = (state_reg == ST_READ) ? SAW'(sp_reg - SPW'(2)) : alu_frame_addr;

    sms_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (16)
    ) u_stack_ram (
        .clk       (clk),
        .wr_en     (commit && (item_reg.command == CMD_STEP) && alu_wr_en),
        .wr_addr   (alu_wr_addr),
        .wr_data   (alu_wr_data),
        .rd_en_a   (state_reg == ST_READ),
        .rd_addr_a (SAW'(sp_reg - SPW'(1))),
        .rd_data_a (stack_top),
        .rd_en_b   (stack_rd_en_b),
        .rd_addr_b (stack_rd_addr_b),
        .rd_data_b (stack_b)
    );

    sms_alu #(
        .CODE_DEPTH  (CODE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_sms_alu (
        .code_op      (code_op),
        .code_arg     (code_arg),
        .top_value    (stack_top),
        .second_value (second_reg),
        .frame_value  (stack_b),
        .pc           (pc_reg),
        .sp           (sp_reg),
        .fp           (fp_reg),
        .frame_addr   (alu_frame_addr),
        .status       (alu_status),
        .pc_new       (alu_pc),
        .sp_new       (alu_sp),
        .fp_new       (alu_fp),
        .wr_en        (alu_wr_en),
        .wr_addr      (alu_wr_addr),
        .wr_data      (alu_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            sp_reg        <= '0;
            fp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            fp_reg        <= fp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (state_reg == ST_FRAME)
        begin
            second_reg <= stack_b;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.command == CMD_STEP) ? ST_READ : ST_EXEC;
                end
            end
            ST_READ:
            begin
                state_next = ST_FRAME;
            end
            ST_FRAME:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    if (accept)
                    begin
                        state_next = (req.command == CMD_STEP) ? ST_READ : ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // architectural registers after the retiring transaction
    always_comb
    begin
        pc_next = pc_reg;
        sp_next = sp_reg;
        fp_next = fp_reg;
        if (commit)
        begin
            case (item_reg.command)
                CMD_START:
                begin
                    pc_next = '0;
                    sp_next = '0;
                    fp_next = '0;
                end
                CMD_STEP:
                begin
                    if (exec_ok)
                    begin
                        pc_next = alu_pc;
                        sp_next = alu_sp;
                        fp_next = alu_fp;
                    end
                end
                default:
                begin
                    pc_next = pc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next.program_counter_out = 10'(pc_next);
        rsp_next.stack_pointer_out   = 11'(sp_next);
        if (item_reg.command == CMD_STEP)
        begin
            rsp_next.print_value = alu_status.print_value;
            rsp_next.print_valid = alu_status.print_valid;
            rsp_next.halted      = alu_status.halted;
            rsp_next.error_code  = alu_status.error_code;
        end
        else
        begin
            rsp_next.print_value = 16'sd0;
            rsp_next.print_valid = 1'b0;
            rsp_next.halted      = 1'b0;
            rsp_next.error_code  = ERR_NONE;
        end
    end

    assign rsp_valid_next = commit || (rsp_valid_reg && rsp_stall);
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

endmodule

[design/sms_ram.sv]
module sms_ram
    import sms_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en_a,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic             rd_en_b,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en_a)
        begin
            rd_data_a <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[design/sms_alu.sv]
module sms_alu
    import sms_pkg::*;
#(
    parameter int CODE_DEPTH  = 1024,
    parameter int STACK_DEPTH = 1024,
    parameter int CAW         = $clog2(CODE_DEPTH),
    parameter int SPW         = $clog2(STACK_DEPTH + 1),
    parameter int SAW         = $clog2(STACK_DEPTH)
)
(
    input  logic [15:0]     code_op,
    input  logic [15:0]     code_arg,
    input  logic [15:0]     top_value,
    input  logic [15:0]     second_value,
    input  logic [15:0]     frame_value,
    input  logic [CAW-1:0]  pc,
    input  logic [SPW-1:0]  sp,
    input  logic [SAW-1:0]  fp,
    output logic [SAW-1:0]  frame_addr,
    output sms_status_t     status,
    output logic [CAW-1:0]  pc_new,
    output logic [SPW-1:0]  sp_new,
    output logic [SAW-1:0]  fp_new,
    output logic            wr_en,
    output logic [SAW-1:0]  wr_addr,
    output logic [15:0]     wr_data
);

    localparam int MW = (CAW > SPW) ? CAW : SPW;
    localparam int XW = ((MW > 16) ? MW : 16) + 3;

    localparam logic signed [XW-1:0] ZERO_X = XW'(0);
    localparam logic signed [XW-1:0] ONE_X  = XW'(1);
    localparam logic signed [XW-1:0] TWO_X  = XW'(2);
    localparam logic signed [XW-1:0] CD_X   = XW'(CODE_DEPTH);
    localparam logic signed [XW-1:0] SD_X   = XW'(STACK_DEPTH);

    logic signed [XW-1:0] pc_x;
    logic signed [XW-1:0] sp_x;
    logic signed [XW-1:0] fp_x;
    logic signed [XW-1:0] arg_x;
    logic signed [XW-1:0] fa_x;
    logic signed [XW-1:0] npc_x;
    logic signed [XW-1:0] nsp_x;
    logic signed [XW-1:0] nfp_x;
    logic signed [XW-1:0] waddr_x;
    logic                 fa_ok;
    logic                 has_arg;
    logic                 unknown;
    logic                 stack_err;
    logic                 wen;
    logic                 pvalid;
    logic [15:0]          pval;
    logic [15:0]          wval;
    logic [1:0]           err;
    logic                 halt;

    assign pc_x  = XW'(pc);
    assign sp_x  = XW'(sp);
    assign fp_x  = XW'(fp);
    assign arg_x = XW'($signed(code_arg));

    // UNLK reads the saved frame link, LOAD and STORE a frame slot
    assign fa_x       = (code_op == OP_UNLK) ? fp_x : (fp_x + arg_x);
    assign fa_ok      = (fa_x >= ZERO_X) && (fa_x < SD_X);
    assign frame_addr = fa_x[SAW-1:0];

    assign has_arg = (code_op >= OP_CALL) && (code_op <= OP_STORE);
    assign unknown = (code_op == OP_BAD) || (code_op > OP_STORE);

    always_comb
    begin
        err       = ERR_NONE;
        halt      = 1'b0;
        pvalid    = 1'b0;
        pval      = 16'd0;
        wen       = 1'b0;
        waddr_x   = ZERO_X;
        wval      = 16'd0;
        npc_x     = pc_x + ONE_X;
        nsp_x     = sp_x;
        nfp_x     = fp_x;
        stack_err = 1'b0;
        if (code_op == OP_HALT)
        begin
            halt = 1'b1;
        end
        else if (unknown)
        begin
            err = ERR_OPCODE;
        end
        else if (has_arg && (pc_x + ONE_X >= CD_X))
        begin
            err = ERR_CODE;
        end
        else
        begin
            if (has_arg)
            begin
                npc_x = pc_x + TWO_X;
            end
            case (code_op)
                OP_ADD, OP_MPY, OP_SUB, OP_CMP:
                begin
                    stack_err = sp_x < TWO_X;
                    waddr_x   = sp_x - TWO_X;
                    wen       = 1'b1;
                    nsp_x     = sp_x - ONE_X;
                    if (code_op == OP_ADD)
                    begin
                        wval = top_value + second_value;
                    end
                    else if (code_op == OP_MPY)
                    begin
                        wval = top_value * second_value;
                    end
                    else if (code_op == OP_SUB)
                    begin
                        wval = second_value - top_value;
                    end
                    else
                    begin
                        wval = {15'd0, $signed(second_value) < $signed(top_value)};
                    end
                end
                OP_DOT:
                begin
                    stack_err = sp_x < ONE_X;
                    pval      = top_value;
                    pvalid    = 1'b1;
                    nsp_x     = sp_x - ONE_X;
                end
                OP_UNLK:
                begin
                    nfp_x     = XW'(frame_value);
                    stack_err = XW'(frame_value) >= SD_X;
                    nsp_x     = fp_x;
                end
                OP_CALL:
                begin
                    stack_err = sp_x >= SD_X;
                    waddr_x   = sp_x;
                    wval      = 16'(pc_x + TWO_X);
                    wen       = 1'b1;
                    nsp_x     = sp_x + ONE_X;
                    npc_x     = XW'(code_arg);
                end
                OP_EXIT:
                begin
                    npc_x     = XW'(top_value);
                    nsp_x     = sp_x - ONE_X - arg_x;
                    stack_err = (sp_x < ONE_X) || (nsp_x < ZERO_X) || (nsp_x > SD_X);
                end
                OP_INT:
                begin
                    stack_err = sp_x >= SD_X;
                    waddr_x   = sp_x;
                    wval      = code_arg;
                    wen       = 1'b1;
                    nsp_x     = sp_x + ONE_X;
                end
                OP_JMP:
                begin
                    npc_x = pc_x + TWO_X + arg_x;
                end
                OP_JZR:
                begin
                    stack_err = sp_x < ONE_X;
                    if (top_value == 16'd0)
                    begin
                        npc_x = pc_x + TWO_X + arg_x;
                    end
                    nsp_x = sp_x - ONE_X;
                end
                OP_LINK:
                begin
                    waddr_x   = sp_x;
                    wval      = 16'(fp_x);
                    wen       = 1'b1;
                    nfp_x     = sp_x;
                    nsp_x     = sp_x + ONE_X + arg_x;
                    stack_err = (sp_x >= SD_X) || (nsp_x < ZERO_X) || (nsp_x > SD_X);
                end
                OP_LOAD:
                begin
                    stack_err = (sp_x >= SD_X) || !fa_ok;
                    waddr_x   = sp_x;
                    wval      = frame_value;
                    wen       = 1'b1;
                    nsp_x     = sp_x + ONE_X;
                end
                OP_STORE:
                begin
                    stack_err = (sp_x < ONE_X) || !fa_ok;
                    waddr_x   = fa_x;
                    wval      = top_value;
                    wen       = 1'b1;
                    nsp_x     = sp_x - ONE_X;
                end
                default:
                begin
                    stack_err = 1'b0;
                end
            endcase
            // stack faults take precedence over a bad jump target
            if (stack_err)
            begin
                err = ERR_STACK;
            end
            else if ((npc_x < ZERO_X) || (npc_x >= CD_X))
            begin
                err = ERR_CODE;
            end
        end
    end

    assign status.error_code  = err;
    assign status.halted      = halt;
    assign status.print_valid = pvalid && (err == ERR_NONE);
    assign status.print_value = (pvalid && (err == ERR_NONE)) ? pval : 16'd0;

    assign pc_new  = npc_x[CAW-1:0];
    assign sp_new  = nsp_x[SPW-1:0];
    assign fp_new  = nfp_x[SAW-1:0];
    assign wr_en   = wen && (err == ERR_NONE) && !halt;
    assign wr_addr = waddr_x[SAW-1:0];
    assign wr_data = wval;

endmodule

[design/sms_checker.sv]
module sms_checker
    import sms_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input sms_rsp_t rsp
);

    logic        rsp_take;
    logic [9:0]  last_pc_reg;
    logic [10:0] last_sp_reg;

    assign rsp_take = rsp_valid && !rsp_stall;

    // registers as reported by the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pc_reg <= '0;
            last_sp_reg <= '0;
        end
        else if (rsp_take)
        begin
            last_pc_reg <= rsp.program_counter_out;
            last_sp_reg <= rsp.stack_pointer_out;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    a_print_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.print_valid |-> rsp.error_code == ERR_NONE && !rsp.halted)
        else $error("print reported together with a fault or halt");

    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.halted |-> rsp.error_code == ERR_NONE && rsp.print_value == 16'sd0)
        else $error("halt reported with an error or a print value");

    a_fault_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take && (rsp.error_code != ERR_NONE || rsp.halted)
        |-> rsp.program_counter_out == last_pc_reg && rsp.stack_pointer_out == last_sp_reg)
        else $error("faulting or halted step moved pc or sp");

endmodule

bind stack_machine_step sms_checker u_sms_checker (.*);

[verif/stack_machine_step_tb.sv]
module stack_machine_step_tb
    import sms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_DEPTH   = 1024;
    localparam int STACK_DEPTH  = 1024;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    // command three is not decoded by the core
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    sms_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    sms_rsp_t rsp;

    stack_machine_step dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // testbench copy of the core
    logic [15:0] code_mem [CODE_DEPTH];
    bit          code_known [CODE_DEPTH];
    logic [15:0] stack_mem [STACK_DEPTH];
    bit          stack_known [STACK_DEPTH];
    int          mach_pc;
    int          mach_sp;
    int          mach_fp;
    int          missing_code;
    bit          missing_stack;

    sms_rsp_t machine_outcomes [$];
    sms_rsp_t last_outcome;
    sms_rsp_t want;

    int send_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int n_bad;
    int n_results;
    int n_counted;
    int n_steps;
    int n_halts;
    int n_prints;
    int n_faults;

    function automatic logic [15:0] code_at(int a);
        if (!code_known[a])
        begin
            if (missing_code < 0)
                missing_code = a;
            return 16'h0000;
        end
        return code_mem[a];
    endfunction

    function automatic logic [15:0] stack_at(int a);
        if (!stack_known[a])
        begin
            missing_stack = 1'b1;
            return 16'h0000;
        end
        return stack_mem[a];
    endfunction

    // one instruction at the program counter; state is only updated when commit is set
    function automatic logic [1:0] execute_instruction(input bit commit,
                                                       output logic [15:0] pval,
                                                       output bit pvalid,
                                                       output bit phalt);
        int          pc = mach_pc;
        int          sp = mach_sp;
        int          fp = mach_fp;
        int          npc;
        int          nsp = mach_sp;
        int          nfp = mach_fp;
        int          waddr = 0;
        int          sarg;
        logic [15:0] op;
        logic [15:0] arg = 16'h0000;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] wval = 16'h0000;
        bit          wen = 1'b0;
        pval = 16'h0000;
        pvalid = 1'b0;
        phalt = 1'b0;
        op = code_at(pc);
        if (op == OP_HALT)
        begin
            phalt = 1'b1;
            return ERR_NONE;
        end
        if (op == OP_BAD || op > OP_STORE)
            return ERR_OPCODE;
        if (op > OP_BAD)
        begin
            if (pc + 1 >= CODE_DEPTH)
                return ERR_CODE;
            arg = code_at(pc + 1);
            npc = pc + 2;
        end
        else
            npc = pc + 1;
        sarg = $signed(arg);

        case (op)
            OP_ADD, OP_MPY, OP_SUB, OP_CMP:
            begin
                if (sp < 2)
                    return ERR_STACK;
                a = stack_at(sp - 1);
                b = stack_at(sp - 2);
                case (op)
                    OP_ADD: wval = a + b;
                    OP_MPY: wval = a * b;
                    OP_SUB: wval = b - a;
                    default: wval = ($signed(b) < $signed(a)) ? 16'd1 : 16'd0;
                endcase
                waddr = sp - 2;
                wen = 1'b1;
                nsp = sp - 1;
            end
            OP_DOT:
            begin
                if (sp < 1)
                    return ERR_STACK;
                pval = stack_at(sp - 1);
                pvalid = 1'b1;
                nsp = sp - 1;
            end
            OP_UNLK:
            begin
                if (fp < 0 || fp >= STACK_DEPTH)
                    return ERR_STACK;
                nfp = stack_at(fp);
                if (nfp >= STACK_DEPTH)
                    return ERR_STACK;
                nsp = fp;
            end
            OP_CALL:
            begin
                if (sp >= STACK_DEPTH)
                    return ERR_STACK;
                waddr = sp;
                wval = 16'(pc + 2);
                wen = 1'b1;
                nsp = sp + 1;
                npc = arg;
            end
            OP_EXIT:
            begin
                if (sp < 1)
                    return ERR_STACK;
                npc = stack_at(sp - 1);
                nsp = sp - 1 - sarg;
                if (nsp < 0 || nsp > STACK_DEPTH)
                    return ERR_STACK;
            end
            OP_INT:
            begin
                if (sp >= STACK_DEPTH)
                    return ERR_STACK;
                waddr = sp;
                wval = arg;
                wen = 1'b1;
                nsp = sp + 1;
            end
            OP_JMP:
                npc = pc + 2 + sarg;
            OP_JZR:
            begin
                if (sp < 1)
                    return ERR_STACK;
                if (stack_at(sp - 1) == 16'h0000)
                    npc = pc + 2 + sarg;
                nsp = sp - 1;
            end
            OP_LINK:
            begin
                if (sp >= STACK_DEPTH)
                    return ERR_STACK;
                waddr = sp;
                wval = 16'(fp);
                wen = 1'b1;
                nfp = sp;
                nsp = sp + 1 + sarg;
                if (nsp < 0 || nsp > STACK_DEPTH)
                    return ERR_STACK;
            end
            OP_LOAD:
            begin
                if (sp >= STACK_DEPTH)
                    return ERR_STACK;
                if (fp + sarg < 0 || fp + sarg >= STACK_DEPTH)
                    return ERR_STACK;
                wval = stack_at(fp + sarg);
                waddr = sp;
                wen = 1'b1;
                nsp = sp + 1;
            end
            default:
            begin
                if (sp < 1)
                    return ERR_STACK;
                waddr = fp + sarg;
                if (waddr < 0 || waddr >= STACK_DEPTH)
                    return ERR_STACK;
                wval = stack_at(sp - 1);
                wen = 1'b1;
                nsp = sp - 1;
            end
        endcase

        if (npc < 0 || npc >= CODE_DEPTH)
        begin
            pval = 16'h0000;
            pvalid = 1'b0;
            return ERR_CODE;
        end
        if (commit)
        begin
            if (wen)
            begin
                stack_mem[waddr] = wval;
                stack_known[waddr] = 1'b1;
            end
            mach_pc = npc;
            mach_sp = nsp;
            mach_fp = nfp;
        end
        return ERR_NONE;
    endfunction

    // works out the result of one request; returns 1 if it would touch a word never written
    function automatic bit apply_item(input sms_req_t r, input bit commit, output sms_rsp_t o);
        logic [15:0] pv;
        bit          pvalid;
        bit          phalt;
        missing_code = -1;
        missing_stack = 1'b0;
        o = '0;
        case (r.command)
            CMD_WRITE:
                if (commit)
                begin
                    code_mem[r.code_address] = r.code_word;
                    code_known[r.code_address] = 1'b1;
                end
            CMD_START:
                if (commit)
                begin
                    mach_pc = 0;
                    mach_sp = 0;
                    mach_fp = 0;
                end
            CMD_STEP:
            begin
                o.error_code = execute_instruction(commit, pv, pvalid, phalt);
                o.print_value = pv;
                o.print_valid = pvalid;
                o.halted = phalt;
            end
            default: ;
        endcase
        o.program_counter_out = mach_pc[9:0];
        o.stack_pointer_out = mach_sp[10:0];
        return missing_code >= 0 || missing_stack;
    endfunction

    function automatic sms_req_t make_req(logic [1:0] cmd, logic [9:0] addr, logic [15:0] word);
        sms_req_t r;
        r.command = cmd;
        r.code_address = addr;
        r.code_word = word;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("mismatch on %s: got %0d, expected %0d (at %0t)", what, got, exp_val, $realtime);
        n_bad++;
    endtask

    task automatic send_item(input sms_req_t r);
        sms_rsp_t o;
        void'(apply_item(r, 1'b1, o));
        machine_outcomes.push_back(o);
        last_outcome = o;
        if (r.command != CMD_NONE)
            n_counted++;
        if (r.command == CMD_STEP)
        begin
            n_steps++;
            n_halts += o.halted;
            n_prints += o.print_valid;
            if (o.error_code != ERR_NONE)
                n_faults++;
        end
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic put_code(int addr, logic [15:0] word);
        send_item(make_req(CMD_WRITE, addr[9:0], word));
    endtask

    task automatic load_program(int base, logic [15:0] words [$]);
        for (int i = 0; i < words.size(); i++)
            put_code(base + i, words[i]);
    endtask

    task automatic step_times(int n);
        repeat (n)
            send_item(make_req(CMD_STEP, 10'($urandom), 16'($urandom)));
    endtask

    // fills in code words the next step would fetch; ok is 0 if it would read an empty stack slot
    task automatic ready_step(output bit ok);
        sms_rsp_t o;
        logic [15:0] word;
        ok = 1'b0;
        repeat (3)
        begin
            if (!apply_item(make_req(CMD_STEP, '0, '0), 1'b0, o))
            begin
                ok = 1'b1;
                return;
            end
            if (missing_code < 0)
                return;
            if (missing_code == mach_pc)
                word = 16'($urandom_range(0, 15));
            else if ($urandom_range(99) < 80)
                word = 16'($urandom_range(0, 12) - 4);
            else
                word = 16'($urandom);
            put_code(missing_code, word);
        end
    endtask

    task automatic random_noise();
        case ($urandom_range(2))
            0: send_item(make_req(CMD_WRITE, 10'($urandom), 16'($urandom)));
            1: send_item(make_req(CMD_NONE, 10'($urandom), 16'($urandom)));
            default: send_item(make_req(CMD_START, 10'($urandom), 16'($urandom)));
        endcase
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (machine_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // every opcode but JMP and BAD in one program, including a frame, a call and a return
    task automatic test_instruction_set();
        logic [15:0] words [$];
        words = {OP_INT, 16'd5, OP_INT, 16'd7, OP_SUB, OP_INT, 16'hFFFD, OP_CMP,
                 OP_JZR, 16'd2, OP_HALT, OP_HALT, OP_LINK, 16'd1, OP_INT, 16'd9,
                 OP_STORE, 16'd1, OP_LOAD, 16'd1, OP_INT, 16'h7FFF, OP_ADD,
                 OP_INT, 16'hFFFF, OP_MPY, OP_DOT, OP_UNLK, OP_CALL, 16'd32,
                 OP_HALT, OP_HALT, OP_EXIT, 16'd0};
        load_program(0, words);
        send_item(make_req(CMD_START, 10'h3FF, 16'hFFFF));
        step_times(10);
        send_item(make_req(CMD_NONE, 10'h000, 16'h0000));
        step_times(10);
    endtask

    task automatic test_faults();
        // unknown opcodes on top of the halt
        put_code(30, OP_BAD);
        step_times(1);
        put_code(30, 16'hFFFF);
        step_times(1);
        put_code(30, 16'd16);
        step_times(1);
        // pop from an empty stack
        send_item(make_req(CMD_START, 10'd0, 16'd0));
        put_code(0, OP_DOT);
        step_times(1);
        // jump below the code store, then operand fetch past its end
        put_code(0, OP_JMP);
        put_code(1, 16'hFFFD);
        step_times(1);
        put_code(1, 16'd1021);
        step_times(1);
        put_code(1023, OP_INT);
        step_times(1);
        // unlink to a frame pointer beyond the stack
        send_item(make_req(CMD_START, 10'd0, 16'd0));
        load_program(0, {OP_INT, 16'h8000, OP_UNLK});
        step_times(2);
        // frame that fills the stack, then push and frame store out of range
        load_program(2, {OP_LINK, 16'd1022, OP_INT, 16'd1});
        step_times(2);
        load_program(4, {OP_STORE, 16'hFFFE});
        step_times(1);
        put_code(4, OP_UNLK);
        step_times(2);
        // return that drops too much, then return to an address past the code store
        load_program(5, {OP_EXIT, 16'h8000});
        step_times(1);
        put_code(6, 16'd0);
        step_times(1);
        send_item(make_req(CMD_NONE, 10'h3FF, 16'hFFFF));
        send_item(make_req(CMD_START, 10'd0, 16'd0));
    endtask

    task automatic random_program_run();
        logic [15:0] words [$];
        logic [15:0] corner_vals [5] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
        logic [15:0] arith_ops [4] = '{OP_ADD, OP_MPY, OP_SUB, OP_CMP};
        int len;
        int pick;
        int steps;
        int halts = 0;
        int fails = 0;
        bit ok;
        len = $urandom_range(3, 28);
        while (words.size() < len)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                words.push_back(OP_INT);
                case ($urandom_range(3))
                    0, 1: words.push_back(16'($urandom_range(0, 20)));
                    2: words.push_back(16'($urandom));
                    default: words.push_back(corner_vals[$urandom_range(4)]);
                endcase
            end
            else if (pick < 40)
                words.push_back(arith_ops[$urandom_range(3)]);
            else if (pick < 50)
                words.push_back(OP_DOT);
            else if (pick < 58)
                words = {words, OP_JZR, 16'($urandom_range(0, 12) - 6)};
            else if (pick < 63)
                words = {words, OP_JMP, 16'($urandom_range(0, 10) - 4)};
            else if (pick < 70)
                words = {words, OP_CALL, 16'($urandom_range(0, len))};
            else if (pick < 75)
                words = {words, OP_EXIT, 16'($urandom_range(0, 3) - 1)};
            else if (pick < 82)
            begin
                words.push_back(OP_LINK);
                if ($urandom_range(9) == 0)
                    words.push_back(16'($urandom_range(900, 1023)));
                else
                    words.push_back(16'($urandom_range(0, 3)));
            end
            else if (pick < 86)
                words.push_back(OP_UNLK);
            else if (pick < 91)
                words = {words, OP_LOAD, 16'($urandom_range(0, 6) - 3)};
            else if (pick < 96)
                words = {words, OP_STORE, 16'($urandom_range(0, 6) - 3)};
            else if (pick < 98)
                words.push_back(OP_HALT);
            else
                words.push_back(16'($urandom));
        end
        words.push_back(OP_HALT);
        load_program(0, words);
        if ($urandom_range(9) != 0)
            send_item(make_req(CMD_START, 10'($urandom), 16'($urandom)));

        steps = $urandom_range(8, 70);
        for (int s = 0; s < steps; s++)
        begin
            if ($urandom_range(99) < 5)
                random_noise();
            ready_step(ok);
            if (!ok)
                break;
            send_item(make_req(CMD_STEP, 10'($urandom), 16'($urandom)));
            if (last_outcome.halted)
            begin
                halts++;
                if (halts >= 2)
                    break;
            end
            else if (last_outcome.error_code != ERR_NONE)
            begin
                fails++;
                if (fails >= 3)
                    break;
            end
        end
    endtask

    task automatic test_random_programs(int quota);
        int target;
        target = n_counted + quota;
        while (n_counted < target)
            random_program_run();
    endtask

    // response side: random stall, compare against the oldest outstanding prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (machine_outcomes.size() == 0)
                report_mismatch("response with nothing outstanding", 0, 0);
            else
            begin
                want = machine_outcomes.pop_front();
                n_results++;
                if (rsp.program_counter_out !== want.program_counter_out)
                    report_mismatch("program_counter_out", rsp.program_counter_out,
                                    want.program_counter_out);
                if (rsp.stack_pointer_out !== want.stack_pointer_out)
                    report_mismatch("stack_pointer_out", rsp.stack_pointer_out,
                                    want.stack_pointer_out);
                if (rsp.print_value !== want.print_value)
                    report_mismatch("print_value", rsp.print_value, want.print_value);
                if (rsp.print_valid !== want.print_valid)
                    report_mismatch("print_valid", rsp.print_valid, want.print_valid);
                if (rsp.halted !== want.halted)
                    report_mismatch("halted", rsp.halted, want.halted);
                if (rsp.error_code !== want.error_code)
                    report_mismatch("error_code", rsp.error_code, want.error_code);
            end
        end
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, machine_outcomes.size());
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        mach_pc = 0;
        mach_sp = 0;
        mach_fp = 0;
        send_gap_pct = 29;
        recv_stall_pct = 55;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_instruction_set();
        test_faults();
        test_random_programs(500);
        send_gap_pct = 55;
        recv_stall_pct = 29;
        test_random_programs(500);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_programs(500);
        drain();

        $display("%0d requests: %0d steps, %0d halts, %0d prints, %0d faulting steps",
                 n_counted, n_steps, n_halts, n_prints, n_faults);
        $display("%0d responses checked, %0d mismatches", n_results, n_bad);
        if (n_bad == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
